### hw/rtl/reef_pkg.sv
// Shared types, constants and face tables of the reference element exit face block.
`timescale 1ns / 1ps
`default_nettype none

package reef_pkg;

    localparam int FRAC_BITS_DEF = 24;

    localparam logic [30:0] TOL_RESET = 31'd17;
    localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;
    localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;

    localparam logic [2:0] SHAPE_TRI   = 3'd0;
    localparam logic [2:0] SHAPE_QUAD  = 3'd1;
    localparam logic [2:0] SHAPE_TET   = 3'd2;
    localparam logic [2:0] SHAPE_PRISM = 3'd3;
    localparam logic [2:0] SHAPE_HEX   = 3'd4;

    localparam logic [1:0] NORM_UNIT = 2'd1;
    localparam logic [1:0] NORM_SQ2  = 2'd2;
    localparam logic [1:0] NORM_SQ3  = 2'd3;

    localparam logic REG_TOL = 1'b0;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        time_left;
    } reef_req_t;

    typedef struct packed {
        logic               crossed;
        logic [2:0]         face;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic [30:0]        time_back;
    } reef_rsp_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } reef_item_t;

    typedef struct packed {
        reef_item_t item;
        logic [2:0] en;
        logic [2:0] ok;
        logic [2:0] f0;
        logic [2:0] f1;
        logic [2:0] f2;
    } reef_meta_t;

    typedef struct packed {
        logic [1:0] n;
        logic [2:0] l0;
        logic [2:0] l1;
        logic [2:0] l2;
    } reef_cand_t;

    typedef struct packed {
        logic signed [1:0] mx;
        logic signed [1:0] my;
        logic signed [1:0] mz;
        logic signed [1:0] k;
        logic [1:0]        s;
    } reef_plane_t;

    function automatic reef_cand_t mk_cand(int n, int a, int b, int c);
        reef_cand_t r;
        r.n  = 2'(n);
        r.l0 = 3'(a);
        r.l1 = 3'(b);
        r.l2 = 3'(c);
        return r;
    endfunction

    function automatic reef_cand_t cand_list(logic [2:0] shape, logic px, logic py,
                                             logic pz, logic ps);
        reef_cand_t c;
        case (shape)
            SHAPE_TRI:
            begin
                if (px)
                    c = py ? mk_cand(1, 1, 0, 0) : (ps ? mk_cand(2, 0, 1, 0) : mk_cand(1, 0, 0, 0));
                else
                    c = py ? (ps ? mk_cand(2, 1, 2, 0) : mk_cand(1, 2, 0, 0)) : mk_cand(2, 0, 2, 0);
            end
            SHAPE_QUAD:
            begin
                if (px)
                    c = py ? mk_cand(2, 1, 2, 0) : mk_cand(2, 0, 1, 0);
                else
                    c = py ? mk_cand(2, 2, 3, 0) : mk_cand(2, 0, 3, 0);
            end
            SHAPE_TET:
            begin
                if (px && py)
                    c = pz ? mk_cand(1, 2, 0, 0) : (ps ? mk_cand(2, 0, 2, 0) : mk_cand(1, 0, 0, 0));
                else if (px)
                    c = pz ? (ps ? mk_cand(2, 1, 2, 0) : mk_cand(1, 1, 0, 0))
                           : (ps ? mk_cand(3, 0, 1, 2) : mk_cand(2, 0, 1, 0));
                else if (py)
                    c = pz ? (ps ? mk_cand(2, 2, 3, 0) : mk_cand(1, 3, 0, 0))
                           : (ps ? mk_cand(3, 0, 2, 3) : mk_cand(2, 0, 3, 0));
                else
                    c = pz ? (ps ? mk_cand(3, 1, 2, 3) : mk_cand(2, 1, 3, 0)) : mk_cand(3, 0, 1, 3);
            end
            SHAPE_PRISM:
            begin
                if (px && py)
                    c = pz ? (ps ? mk_cand(2, 2, 3, 0) : mk_cand(1, 3, 0, 0))
                           : (ps ? mk_cand(3, 0, 2, 3) : mk_cand(2, 0, 3, 0));
                else if (px)
                    c = pz ? (ps ? mk_cand(2, 1, 2, 0) : mk_cand(1, 1, 0, 0))
                           : (ps ? mk_cand(3, 0, 1, 2) : mk_cand(2, 0, 1, 0));
                else if (py)
                    c = pz ? (ps ? mk_cand(3, 2, 3, 4) : mk_cand(2, 3, 4, 0)) : mk_cand(3, 0, 3, 4);
                else
                    c = pz ? (ps ? mk_cand(3, 1, 2, 4) : mk_cand(2, 1, 4, 0)) : mk_cand(3, 0, 1, 4);
            end
            default:
            begin
                if (px && py)
                    c = pz ? mk_cand(3, 2, 3, 5) : mk_cand(3, 0, 2, 3);
                else if (px)
                    c = pz ? mk_cand(3, 1, 2, 5) : mk_cand(3, 0, 1, 2);
                else if (py)
                    c = pz ? mk_cand(3, 3, 4, 5) : mk_cand(3, 0, 3, 4);
                else
                    c = pz ? mk_cand(3, 1, 4, 5) : mk_cand(3, 0, 1, 4);
            end
        endcase
        return c;
    endfunction

    function automatic reef_plane_t mk_plane(int mx, int my, int mz, int k, logic [1:0] s);
        reef_plane_t p;
        p.mx = 2'(mx);
        p.my = 2'(my);
        p.mz = 2'(mz);
        p.k  = 2'(k);
        p.s  = s;
        return p;
    endfunction

    function automatic reef_plane_t plane_of(logic [2:0] shape, logic [2:0] f);
        reef_plane_t p;
        p = mk_plane(0, 0, 0, 0, NORM_UNIT);
        case (shape)
            SHAPE_TRI:
            begin
                case (f)
                    3'd0:    p = mk_plane(0, 1, 0, 1, NORM_UNIT);
                    3'd1:    p = mk_plane(-1, -1, 0, 0, NORM_SQ2);
                    3'd2:    p = mk_plane(1, 0, 0, 1, NORM_UNIT);
                    default: p = mk_plane(0, 0, 0, 0, NORM_UNIT);
                endcase
            end
            SHAPE_QUAD:
            begin
                case (f)
                    3'd0:    p = mk_plane(0, 1, 0, 1, NORM_UNIT);
                    3'd1:    p = mk_plane(-1, 0, 0, 1, NORM_UNIT);
                    3'd2:    p = mk_plane(0, -1, 0, 1, NORM_UNIT);
                    3'd3:    p = mk_plane(1, 0, 0, 1, NORM_UNIT);
                    default: p = mk_plane(0, 0, 0, 0, NORM_UNIT);
                endcase
            end
            SHAPE_TET:
            begin
                case (f)
                    3'd0:    p = mk_plane(0, 0, 1, 1, NORM_UNIT);
                    3'd1:    p = mk_plane(0, 1, 0, 1, NORM_UNIT);
                    3'd2:    p = mk_plane(-1, -1, -1, -1, NORM_SQ3);
                    3'd3:    p = mk_plane(1, 0, 0, 1, NORM_UNIT);
                    default: p = mk_plane(0, 0, 0, 0, NORM_UNIT);
                endcase
            end
            SHAPE_PRISM:
            begin
                case (f)
                    3'd0:    p = mk_plane(0, 0, 1, 1, NORM_UNIT);
                    3'd1:    p = mk_plane(0, 1, 0, 1, NORM_UNIT);
                    3'd2:    p = mk_plane(-1, 0, -1, 0, NORM_SQ2);
                    3'd3:    p = mk_plane(0, -1, 0, 1, NORM_UNIT);
                    3'd4:    p = mk_plane(1, 0, 0, 1, NORM_UNIT);
                    default: p = mk_plane(0, 0, 0, 0, NORM_UNIT);
                endcase
            end
            default:
            begin
                case (f)
                    3'd0:    p = mk_plane(0, 0, 1, 1, NORM_UNIT);
                    3'd1:    p = mk_plane(0, 1, 0, 1, NORM_UNIT);
                    3'd2:    p = mk_plane(-1, 0, 0, 1, NORM_UNIT);
                    3'd3:    p = mk_plane(0, -1, 0, 1, NORM_UNIT);
                    3'd4:    p = mk_plane(1, 0, 0, 1, NORM_UNIT);
                    3'd5:    p = mk_plane(0, 0, -1, 1, NORM_UNIT);
                    default: p = mk_plane(0, 0, 0, 0, NORM_UNIT);
                endcase
            end
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/reef_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the face crossing time.
`timescale 1ns / 1ps
`default_nettype none

module reef_div
    import reef_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic [32:0]             num,
    input  wire logic [32:0]             den,
    output logic      [33+FRAC_BITS-1:0] quo
);

    localparam int QW = 33 + FRAC_BITS;

    logic [32:0]   r_reg [QW];
    logic [QW-1:0] n_reg [QW];
    logic [32:0]   d_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [32:0]   r_in;
        logic [QW-1:0] n_in;
        logic [32:0]   d_in;
        logic [33:0]   trial;
        logic          ge;
        logic [32:0]   r_next;
        logic [QW-1:0] n_next;

        if (j == 0) begin : g_first
            assign r_in = '0;
            assign n_in = {num, FRAC_BITS'(0)};
            assign d_in = den;
        end
        else begin : g_rest
            assign r_in = r_reg[j-1];
            assign n_in = n_reg[j-1];
            assign d_in = d_reg[j-1];
        end

        always_comb
        begin
            trial  = {r_in, n_in[QW-1]};
            ge     = trial >= {1'b0, d_in};
            r_next = ge ? 33'(trial - {1'b0, d_in}) : trial[32:0];
            n_next = {n_in[QW-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            r_reg[j] <= r_next;
            n_reg[j] <= n_next;
            d_reg[j] <= d_in;
        end
    end

    assign quo = n_reg[QW-1];

endmodule

`default_nettype wire

### hw/rtl/reference_element_exit_face.sv
// Exit face finder for a particle in a reference element, fully pipelined.
`timescale 1ns / 1ps
`default_nettype none

// One request enters per clock and busy never rises. Each request yields one
// result on done. The crossing-time divider resolves one quotient bit per
// pipeline stage over 33+FRAC_BITS stages; four stages before it decode the
// shape, build face distances and run the tolerance test, three after it pick
// the face and move the point back. Results cannot be held off: a result is on
// the result port for one cycle only.
// Write the tolerance register only while no request is in flight.

module reference_element_exit_face
    import reef_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire reef_req_t   req,
    output logic             done,
    output reef_rsp_t        result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int QW  = 33 + FRAC_BITS;
    localparam int LAT = QW + 7;
    localparam logic signed [34:0] ONE     = 35'(1) << FRAC_BITS;
    localparam logic signed [34:0] NEG_ONE = -ONE;
    localparam logic [QW-1:0]      MAX31   = QW'(32'h7FFF_FFFF);

    function automatic logic signed [34:0] term(logic signed [1:0] m, logic signed [34:0] x);
        logic signed [34:0] r;
        if (m == 2'sd1)
            r = x;
        else if (m == -2'sd1)
            r = -x;
        else
            r = 35'sd0;
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [64:0] x);
        logic signed [31:0] r;
        if (x > 65'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -65'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    // Configuration
    logic [30:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOL))
            tol_reg <= pwdata[30:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOL) ? {1'b0, tol_reg} : 32'd0;
    assign busy   = 1'b0;

    // Stage 0: capture request
    logic      v0_reg;
    reef_req_t req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req;
    end

    // Stage 1: outside test, candidates, face distances
    logic               v1_reg;
    reef_item_t         item1_reg;
    logic [30:0]        t1_reg;
    logic [2:0]         en1_reg;
    logic [2:0]         f1_reg [3];
    logic signed [34:0] d1_reg [3];
    logic signed [34:0] a1_reg [3];
    logic [1:0]         s1_reg [3];

    logic               two_d;
    logic signed [34:0] px, py, pz, vx, vy, vz, vsum;
    logic               outside;
    reef_cand_t         cand;
    logic [2:0]         lf [3];
    reef_plane_t        pl [3];
    logic [2:0]         en1_next;
    logic signed [34:0] d1_next [3];
    logic signed [34:0] a1_next [3];
    reef_item_t         item1_next;

    always_comb
    begin
        two_d = (req_reg.cmd == SHAPE_TRI) || (req_reg.cmd == SHAPE_QUAD);
        px    = 35'(req_reg.pos_x);
        py    = 35'(req_reg.pos_y);
        pz    = two_d ? 35'sd0 : 35'(req_reg.pos_z);
        vx    = 35'(req_reg.vel_x);
        vy    = 35'(req_reg.vel_y);
        vz    = two_d ? 35'sd0 : 35'(req_reg.vel_z);
        vsum  = vx + vz + ((req_reg.cmd == SHAPE_PRISM) ? 35'sd0 : vy);
        case (req_reg.cmd)
            SHAPE_TRI:   outside = px < NEG_ONE || py < NEG_ONE || px + py > 35'sd0;
            SHAPE_QUAD:  outside = px < NEG_ONE || py < NEG_ONE || px > ONE || py > ONE;
            SHAPE_TET:   outside = px < NEG_ONE || py < NEG_ONE || pz < NEG_ONE ||
                                   px + py + pz > NEG_ONE;
            SHAPE_PRISM: outside = px < NEG_ONE || py < NEG_ONE || pz < NEG_ONE ||
                                   py > ONE || px + pz > 35'sd0;
            SHAPE_HEX:   outside = px < NEG_ONE || py < NEG_ONE || pz < NEG_ONE ||
                                   px > ONE || py > ONE || pz > ONE;
            default:     outside = 1'b0;
        endcase
        cand  = cand_list(req_reg.cmd, vx > 35'sd0, vy > 35'sd0, vz > 35'sd0, vsum > 35'sd0);
        lf[0] = cand.l0;
        lf[1] = cand.l1;
        lf[2] = cand.l2;
        for (int i = 0; i < 3; i++) begin
            pl[i]       = plane_of(req_reg.cmd, lf[i]);
            en1_next[i] = outside && (2'(i) < cand.n);
            d1_next[i]  = term(pl[i].mx, px) + term(pl[i].my, py) + term(pl[i].mz, pz) +
                          term(pl[i].k, ONE);
            a1_next[i]  = -(term(pl[i].mx, vx) + term(pl[i].my, vy) + term(pl[i].mz, vz));
        end
        item1_next.pos_x = req_reg.pos_x;
        item1_next.pos_y = req_reg.pos_y;
        item1_next.pos_z = req_reg.pos_z;
        item1_next.vel_x = req_reg.vel_x;
        item1_next.vel_y = req_reg.vel_y;
        item1_next.vel_z = two_d ? 32'sd0 : req_reg.vel_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        item1_reg <= item1_next;
        t1_reg    <= req_reg.time_left;
        en1_reg   <= en1_next;
        for (int i = 0; i < 3; i++) begin
            f1_reg[i] <= lf[i];
            d1_reg[i] <= d1_next[i];
            a1_reg[i] <= a1_next[i];
            s1_reg[i] <= pl[i].s;
        end
    end

    // Stage 2: sign checks and tolerance products
    logic        v2_reg;
    reef_item_t  item2_reg;
    logic [2:0]  en2_reg;
    logic [2:0]  pre2_reg;
    logic [2:0]  f2_reg [3];
    logic [32:0] nd2_reg [3];
    logic [32:0] am2_reg [3];
    logic [1:0]  s2_reg [3];
    logic [47:0] plo2_reg [3];
    logic [46:0] phi2_reg [3];
    logic [61:0] rq2_reg;
    logic [61:0] rq3_reg;

    logic [32:0] am1 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            am1[i] = a1_reg[i][32:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        item2_reg <= item1_reg;
        en2_reg   <= en1_reg;
        rq2_reg   <= 62'(tol_reg) * 62'(SQRT2_Q30);
        rq3_reg   <= 62'(tol_reg) * 62'(SQRT3_Q30);
        for (int i = 0; i < 3; i++) begin
            pre2_reg[i] <= en1_reg[i] && (d1_reg[i] < 35'sd0) && (a1_reg[i] > 35'sd0);
            f2_reg[i]   <= f1_reg[i];
            nd2_reg[i]  <= 33'(-d1_reg[i]);
            am2_reg[i]  <= am1[i];
            s2_reg[i]   <= s1_reg[i];
            plo2_reg[i] <= 48'(am1[i][16:0]) * 48'(t1_reg);
            phi2_reg[i] <= 47'(am1[i][32:17]) * 47'(t1_reg);
        end
    end

    // Stage 3: tolerance compare
    logic        v3_reg;
    reef_item_t  item3_reg;
    logic [2:0]  en3_reg;
    logic [2:0]  ok3_reg;
    logic [2:0]  f3_reg [3];
    logic [32:0] nd3_reg [3];
    logic [32:0] am3_reg [3];

    logic [63:0] lhs [3];
    logic [63:0] rhs [3];
    logic [2:0]  ok3_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            lhs[i] = 64'(plo2_reg[i]) + (64'(phi2_reg[i]) << 17);
            case (s2_reg[i])
                NORM_SQ2: rhs[i] = 64'(rq2_reg) >> (30 - FRAC_BITS);
                NORM_SQ3: rhs[i] = 64'(rq3_reg) >> (30 - FRAC_BITS);
                default:  rhs[i] = 64'(tol_reg) << FRAC_BITS;
            endcase
            ok3_next[i] = pre2_reg[i] && (lhs[i] > rhs[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        item3_reg <= item2_reg;
        en3_reg   <= en2_reg;
        ok3_reg   <= ok3_next;
        for (int i = 0; i < 3; i++) begin
            f3_reg[i]  <= f2_reg[i];
            nd3_reg[i] <= nd2_reg[i];
            am3_reg[i] <= am2_reg[i];
        end
    end

    // Crossing time dividers with matching side line
    logic [QW-1:0] qq [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        reef_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .num (nd3_reg[i]),
            .den (am3_reg[i]),
            .quo (qq[i])
        );
    end

    logic [QW-1:0] dv_reg;
    reef_meta_t    meta_reg [QW];
    reef_meta_t    meta3;

    always_comb
    begin
        meta3.item = item3_reg;
        meta3.en   = en3_reg;
        meta3.ok   = ok3_reg;
        meta3.f0   = f3_reg[0];
        meta3.f1   = f3_reg[1];
        meta3.f2   = f3_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= '0;
        else
            dv_reg <= {dv_reg[QW-2:0], v3_reg};
    end

    always_ff @(posedge clk)
    begin
        meta_reg[0] <= meta3;
        for (int j = 1; j < QW; j++) begin
            meta_reg[j] <= meta_reg[j-1];
        end
    end

    // Selection
    reef_meta_t    ms;
    logic          bv;
    logic [QW-1:0] bq;
    logic [2:0]    bf;
    logic          vs_reg;
    logic          bv_reg;
    logic [2:0]    bf_reg;
    logic [30:0]   dt_reg;
    reef_item_t    items_reg;

    always_comb
    begin
        ms = meta_reg[QW-1];
        bv = ms.ok[0];
        bq = qq[0];
        bf = ms.f0;
        if (ms.en[1] && !(bv && (!ms.ok[1] || bq > qq[1]))) begin
            bv = ms.ok[1];
            bq = qq[1];
            bf = ms.f1;
        end
        if (ms.en[2] && ms.ok[2] && (!bv || qq[2] > bq)) begin
            bv = 1'b1;
            bq = qq[2];
            bf = ms.f2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vs_reg <= 1'b0;
        else
            vs_reg <= dv_reg[QW-1];
    end

    always_ff @(posedge clk)
    begin
        bv_reg    <= bv;
        bf_reg    <= bf;
        dt_reg    <= (bq > MAX31) ? 31'h7FFF_FFFF : bq[30:0];
        items_reg <= ms.item;
    end

    // Move-back products
    logic               vm_reg;
    logic               bvm_reg;
    logic [2:0]         bfm_reg;
    logic [30:0]        dtm_reg;
    reef_item_t         itemm_reg;
    logic signed [63:0] prod_reg [3];
    logic signed [63:0] dts;

    assign dts = 64'(signed'({1'b0, dt_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else
            vm_reg <= vs_reg;
    end

    always_ff @(posedge clk)
    begin
        bvm_reg     <= bv_reg;
        bfm_reg     <= bf_reg;
        dtm_reg     <= dt_reg;
        itemm_reg   <= items_reg;
        prod_reg[0] <= dts * 64'(items_reg.vel_x);
        prod_reg[1] <= dts * 64'(items_reg.vel_y);
        prod_reg[2] <= dts * 64'(items_reg.vel_z);
    end

    // Output
    logic      done_reg;
    reef_rsp_t rsp_reg;
    reef_rsp_t rsp_next;

    always_comb
    begin
        rsp_next.crossed   = bvm_reg;
        rsp_next.face      = bvm_reg ? bfm_reg : 3'd0;
        rsp_next.time_back = bvm_reg ? dtm_reg : 31'd0;
        if (bvm_reg) begin
            rsp_next.new_x = sat32(65'(itemm_reg.pos_x) - 65'(prod_reg[0] >>> FRAC_BITS));
            rsp_next.new_y = sat32(65'(itemm_reg.pos_y) - 65'(prod_reg[1] >>> FRAC_BITS));
            rsp_next.new_z = sat32(65'(itemm_reg.pos_z) - 65'(prod_reg[2] >>> FRAC_BITS));
        end
        else begin
            rsp_next.new_x = itemm_reg.pos_x;
            rsp_next.new_y = itemm_reg.pos_y;
            rsp_next.new_z = itemm_reg.pos_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vm_reg;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    a_no_cross_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.crossed |-> result.face == 3'd0 && result.time_back == 31'd0)
        else $error("miss result carries face or time");

    a_no_cross_hold: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.crossed |-> result.new_x == $past(req.pos_x, LAT) &&
                                    result.new_y == $past(req.pos_y, LAT) &&
                                    result.new_z == $past(req.pos_z, LAT))
        else $error("miss result moved the point");

    a_cross_needs_time: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.crossed |-> $past(req.time_left, LAT) != 31'd0)
        else $error("crossing reported with zero time left");

endmodule

`default_nettype wire
